// File: rtl/core/csvt_pkg.sv
// ----------------------------------------------------------------------------
// csvt_pkg
// shared types, constants and helpers of the csv record tokenizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package csvt_pkg;

    localparam int MAX_COLUMNS = 32;
    localparam int COL_W       = $clog2(MAX_COLUMNS + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] MARK_0     = 8'hEF;
    localparam logic [7:0] MARK_1     = 8'hBB;
    localparam logic [7:0] MARK_2     = 8'hBF;

    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_EOF  = 1'b1;

    typedef enum logic [1:0] {
        KIND_CONTENT    = 2'd0,
        KIND_FIELD_END  = 2'd1,
        KIND_RECORD_END = 2'd2
    } kind_t;

    // what one accepted word leaves for the back end after any mark bytes
    typedef enum logic [1:0] {
        MAIN_NONE      = 2'd0,
        MAIN_CONTENT   = 2'd1,
        MAIN_FIELD_END = 2'd2,
        MAIN_LINE_END  = 2'd3
    } main_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_MARK = 3'd1,
        PH_MAIN = 3'd2,
        PH_FE   = 3'd3,
        PH_REC  = 3'd4
    } phase_t;

    typedef struct packed {
        logic             is_header;
        logic [1:0]       mark_cnt;
        main_t            main;
        logic [7:0]       byte_val;
        logic [COL_W-1:0] lo;
        logic [COL_W-1:0] hi;
    } cmd_t;

    typedef struct packed {
        logic push;
        cmd_t cmd;
    } push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    function automatic logic [7:0] mark_byte(input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0:    r = MARK_0;
            2'd1:    r = MARK_1;
            default: r = MARK_2;
        endcase
        return r;
    endfunction

    // phase that follows the mark bytes of a command
    function automatic phase_t main_phase(input cmd_t c);
        phase_t p;
        case (c.main)
            MAIN_CONTENT:   p = PH_MAIN;
            MAIN_FIELD_END: p = PH_MAIN;
            MAIN_LINE_END:  p = (c.lo < c.hi) ? PH_FE : PH_REC;
            default:        p = PH_IDLE;
        endcase
        return p;
    endfunction

    function automatic phase_t first_phase(input cmd_t c);
        return (c.mark_cnt != 2'd0) ? PH_MARK : main_phase(c);
    endfunction

endpackage

// File: rtl/core/csvt_front.sv
// ----------------------------------------------------------------------------
// csvt_front
// byte classifier: mark stripping, quoting, column tracking, command issue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csvt_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              s_tuser,
    input  csvt_pkg::qstat_t  qstat,
    output csvt_pkg::push_t   push_out
);

    logic                       quoting_reg, quoting_next;
    logic                       qp_reg, qp_next;
    logic [csvt_pkg::COL_W-1:0] fi_reg, fi_next;
    logic [csvt_pkg::COL_W-1:0] hc_reg, hc_next;
    logic                       hs_reg, hs_next;
    logic                       lhb_reg, lhb_next;
    logic [1:0]                 mm_reg, mm_next;
    logic                       afs_reg, afs_next;

    assign s_tready = !qstat.full;

    always_comb
    begin
        logic [csvt_pkg::COL_W-1:0] lim;
        logic                       below;
        logic [1:0]                 m_idx;
        logic                       take;
        logic                       line_end;
        logic                       q;
        logic                       done;
        csvt_pkg::cmd_t             cmd;

        quoting_next = quoting_reg;
        qp_next      = qp_reg;
        fi_next      = fi_reg;
        hc_next      = hc_reg;
        hs_next      = hs_reg;
        lhb_next     = lhb_reg;
        mm_next      = mm_reg;
        afs_next     = afs_reg;

        lim   = hs_reg ? hc_reg : csvt_pkg::COL_W'(csvt_pkg::MAX_COLUMNS);
        below = fi_reg < lim;
        m_idx = (mm_reg < 2'd3) ? mm_reg : 2'd0;
        take     = 1'b0;
        line_end = 1'b0;
        q        = quoting_reg;
        done     = 1'b0;

        cmd           = '0;
        cmd.is_header = !hs_reg;
        cmd.main      = csvt_pkg::MAIN_NONE;
        cmd.byte_val  = s_tdata;
        cmd.lo        = fi_reg;
        cmd.hi        = fi_reg;

        if (s_tvalid && s_tready)
        begin
            if (s_tuser == csvt_pkg::REQ_DATA)
            begin
                if (afs_reg)
                begin
                    if (s_tdata == csvt_pkg::mark_byte(m_idx))
                    begin
                        lhb_next = 1'b1;
                        if (m_idx == 2'd2)
                        begin
                            mm_next  = 2'd0;
                            afs_next = 1'b0;
                        end
                        else
                        begin
                            mm_next = m_idx + 2'd1;
                        end
                    end
                    else
                    begin
                        // partial mark goes out as content ahead of this byte
                        afs_next     = 1'b0;
                        mm_next      = 2'd0;
                        cmd.mark_cnt = mm_reg;
                        take         = 1'b1;
                    end
                end
                else
                begin
                    take = 1'b1;
                end

                if (take)
                begin
                    if (s_tdata == csvt_pkg::CHAR_NL)
                    begin
                        line_end = 1'b1;
                    end
                    else
                    begin
                        lhb_next = 1'b1;
                        if (qp_reg)
                        begin
                            qp_next = 1'b0;
                            if (s_tdata == csvt_pkg::CHAR_QUOTE)
                            begin
                                if (below)
                                    cmd.main = csvt_pkg::MAIN_CONTENT;
                                done = 1'b1;
                            end
                            else
                            begin
                                q = 1'b0;
                            end
                        end
                        if (!done)
                        begin
                            if (s_tdata == csvt_pkg::CHAR_QUOTE)
                            begin
                                if (q)
                                    qp_next = 1'b1;
                                else
                                    q = 1'b1;
                            end
                            else if (s_tdata == csvt_pkg::CHAR_COMMA && !q)
                            begin
                                if (below)
                                begin
                                    cmd.main = csvt_pkg::MAIN_FIELD_END;
                                    fi_next  = fi_reg + 1'b1;
                                end
                            end
                            else if (below)
                            begin
                                cmd.main = csvt_pkg::MAIN_CONTENT;
                            end
                        end
                        quoting_next = q;
                    end
                end
            end
            else
            begin
                cmd.mark_cnt = afs_reg ? mm_reg : 2'd0;
                line_end     = lhb_reg;
            end

            if (line_end)
            begin
                if (!(hs_reg && !lhb_reg))
                begin
                    cmd.main = csvt_pkg::MAIN_LINE_END;
                    if (hs_reg)
                        cmd.hi = lim;
                    else
                        cmd.hi = below ? fi_reg + 1'b1 : fi_reg;
                    if (!hs_reg)
                    begin
                        hc_next = below ? fi_reg + 1'b1 : lim;
                        hs_next = 1'b1;
                    end
                end
                quoting_next = 1'b0;
                qp_next      = 1'b0;
                fi_next      = '0;
                lhb_next     = 1'b0;
            end

            // end of file returns everything to the start-of-file state
            if (s_tuser == csvt_pkg::REQ_EOF)
            begin
                quoting_next = 1'b0;
                qp_next      = 1'b0;
                fi_next      = '0;
                hc_next      = '0;
                hs_next      = 1'b0;
                lhb_next     = 1'b0;
                mm_next      = 2'd0;
                afs_next     = 1'b1;
            end
        end

        push_out.cmd  = cmd;
        push_out.push = s_tvalid && s_tready &&
                        ((cmd.main != csvt_pkg::MAIN_NONE) || (cmd.mark_cnt != 2'd0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quoting_reg <= 1'b0;
            qp_reg      <= 1'b0;
            fi_reg      <= '0;
            hc_reg      <= '0;
            hs_reg      <= 1'b0;
            lhb_reg     <= 1'b0;
            mm_reg      <= 2'd0;
            afs_reg     <= 1'b1;
        end
        else
        begin
            quoting_reg <= quoting_next;
            qp_reg      <= qp_next;
            fi_reg      <= fi_next;
            hc_reg      <= hc_next;
            hs_reg      <= hs_next;
            lhb_reg     <= lhb_next;
            mm_reg      <= mm_next;
            afs_reg     <= afs_next;
        end
    end

endmodule

// File: rtl/core/csvt_queue.sv
// ----------------------------------------------------------------------------
// csvt_queue
// short command queue between the classifier and the token generator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csvt_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  csvt_pkg::push_t  push_in,
    input  logic             pop,
    output csvt_pkg::qstat_t qstat,
    output csvt_pkg::cmd_t   head
);

    localparam int CNT_W = csvt_pkg::QPTR_W + 1;

    csvt_pkg::cmd_t              entry_reg [csvt_pkg::QUEUE_DEPTH];
    logic [csvt_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [csvt_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic                        do_push;
    logic                        do_pop;

    assign qstat.full  = count_reg == CNT_W'(csvt_pkg::QUEUE_DEPTH);
    assign qstat.empty = count_reg == '0;
    assign head        = entry_reg[rd_ptr_reg];

    assign do_push = push_in.push && !qstat.full;
    assign do_pop  = pop && !qstat.empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_in.cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/core/csvt_back.sv
// ----------------------------------------------------------------------------
// csvt_back
// token generator: expands commands into result words, with output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csvt_back (
    input  logic             clk,
    input  logic             rst_n,
    input  csvt_pkg::cmd_t   head,
    input  csvt_pkg::qstat_t qstat,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,
    output logic [2:0]       m_tuser,
    output logic             m_tlast
);

    csvt_pkg::phase_t           phase_reg, phase_next;
    csvt_pkg::cmd_t             cmd_reg, cmd_next;
    logic [1:0]                 idx_reg, idx_next;
    logic [csvt_pkg::COL_W-1:0] col_reg, col_next;

    logic                       out_valid_reg, out_valid_next;
    logic [15:0]                out_data_reg, out_data_next;
    logic [2:0]                 out_user_reg, out_user_next;
    logic                       out_last_reg, out_last_next;

    logic                       use_head;
    csvt_pkg::cmd_t             cmd_cur;
    csvt_pkg::phase_t           ph_cur;
    logic [1:0]                 idx_cur;
    logic [csvt_pkg::COL_W-1:0] col_cur;
    csvt_pkg::phase_t           ph_after;
    logic                       done;
    logic                       gen_valid;
    logic                       advance;
    logic                       step;

    csvt_pkg::kind_t            res_kind;
    logic [7:0]                 res_char;
    logic [csvt_pkg::COL_W-1:0] res_col;

    // when idle the head of the queue is worked on directly, no bubble
    assign use_head  = phase_reg == csvt_pkg::PH_IDLE;
    assign cmd_cur   = use_head ? head : cmd_reg;
    assign ph_cur    = use_head ? (qstat.empty ? csvt_pkg::PH_IDLE
                                               : csvt_pkg::first_phase(head))
                                : phase_reg;
    assign idx_cur   = use_head ? 2'd0 : idx_reg;
    assign col_cur   = use_head ? head.lo : col_reg;
    assign gen_valid = ph_cur != csvt_pkg::PH_IDLE;
    assign advance   = !out_valid_reg || m_tready;
    assign step      = gen_valid && advance;
    assign pop       = use_head && step;

    // next phase of the generator
    always_comb
    begin
        ph_after = csvt_pkg::PH_IDLE;
        idx_next = idx_cur;
        col_next = col_cur;
        case (ph_cur)
            csvt_pkg::PH_MARK:
            begin
                if (idx_cur + 2'd1 < cmd_cur.mark_cnt)
                begin
                    ph_after = csvt_pkg::PH_MARK;
                    idx_next = idx_cur + 2'd1;
                end
                else
                begin
                    ph_after = csvt_pkg::main_phase(cmd_cur);
                    col_next = cmd_cur.lo;
                end
            end
            csvt_pkg::PH_FE:
            begin
                if (col_cur + 1'b1 < cmd_cur.hi)
                begin
                    ph_after = csvt_pkg::PH_FE;
                    col_next = col_cur + 1'b1;
                end
                else
                begin
                    ph_after = csvt_pkg::PH_REC;
                end
            end
            default:
            begin
                ph_after = csvt_pkg::PH_IDLE;
            end
        endcase
        done       = ph_after == csvt_pkg::PH_IDLE;
        phase_next = step ? ph_after : phase_reg;
        cmd_next   = step ? cmd_cur : cmd_reg;
    end

    // result word of the current phase
    always_comb
    begin
        res_kind = csvt_pkg::KIND_RECORD_END;
        res_char = 8'h00;
        res_col  = '0;
        case (ph_cur)
            csvt_pkg::PH_MARK:
            begin
                res_kind = csvt_pkg::KIND_CONTENT;
                res_char = csvt_pkg::mark_byte(idx_cur);
            end
            csvt_pkg::PH_MAIN:
            begin
                if (cmd_cur.main == csvt_pkg::MAIN_CONTENT)
                begin
                    res_kind = csvt_pkg::KIND_CONTENT;
                    res_char = cmd_cur.byte_val;
                end
                else
                begin
                    res_kind = csvt_pkg::KIND_FIELD_END;
                end
                res_col = cmd_cur.lo;
            end
            csvt_pkg::PH_FE:
            begin
                res_kind = csvt_pkg::KIND_FIELD_END;
                res_col  = col_cur;
            end
            default:
            begin
                res_kind = csvt_pkg::KIND_RECORD_END;
            end
        endcase
    end

    always_comb
    begin
        logic [csvt_pkg::COL_W+4:0] col_wide;

        col_wide       = {5'b0, res_col};
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_last_next  = out_last_reg;
        if (advance)
        begin
            out_valid_next = gen_valid;
            out_data_next  = {3'b000, col_wide[4:0], res_char};
            out_user_next  = {cmd_cur.is_header, res_kind};
            out_last_next  = done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= csvt_pkg::PH_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
        if (step)
        begin
            idx_reg <= idx_next;
            col_reg <= col_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: rtl/core/csv_record_tokenizer_top.sv
// ----------------------------------------------------------------------------
// csv_record_tokenizer_top
// streaming csv tokenizer: file bytes in, field and record tokens out
// ----------------------------------------------------------------------------
// input word: s_tuser is 0 for a file byte in s_tdata, 1 for end of file.
// output word: a content byte, a field end or a record end (kind in m_tuser),
// with its column; m_tlast marks the final word caused by one input word.
// a leading ef bb bf mark is dropped; the first line sets the column count
// and later rows are padded or cut to it; empty data lines give nothing.
// the first word caused by an input is written into the command queue and
// then passes through the output register before it shows on m_tvalid.
// throughput: while the receiver does not stall, one input word per cycle
// while each gives at most one output word; a line end gives one word per
// padding column plus the record end, and the flushed mark bytes one each,
// generated one per cycle by the token generator, the 4-entry command queue
// absorbing short bursts. when the receiver stalls, the output register
// holds its word, the queue fills and s_tready falls once it is full.
// reset: queue and output empty, tokenizer at the start of a file.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csv_record_tokenizer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // char_out[7:0], column[12:8], zero pad
    output logic [2:0]  m_tuser,   // kind[1:0], is_header[2]
    output logic        m_tlast
);

    csvt_pkg::push_t  push_w;
    csvt_pkg::qstat_t qstat_w;
    csvt_pkg::cmd_t   head_w;
    logic             pop_w;

    csvt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .qstat    (qstat_w),
        .push_out (push_w)
    );

    csvt_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_in (push_w),
        .pop     (pop_w),
        .qstat   (qstat_w),
        .head    (head_w)
    );

    csvt_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head_w),
        .qstat    (qstat_w),
        .pop      (pop_w),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the csv record tokenizer: directed rows then random
// files, each output word compared with the typed word of a pinned row or with
// a token predictor run per input word
`timescale 1ns / 1ps

module testbench;

    import csvt_pkg::*;

    localparam int          LIMIT_CYCLES = 500000;
    localparam int          RANDOM_WORDS = 134;
    localparam logic [23:0] BOM_SEQ      = {MARK_2, MARK_1, MARK_0};

    typedef struct packed {
        kind_t      kind;
        logic [7:0] ch;
        logic [4:0] col;
        logic       hdr;
        logic       last;
    } token_t;

    typedef struct packed {
        logic       req;
        logic [7:0] b;
        logic       pinned;
        kind_t      kind;
        logic [7:0] ch;
        logic [4:0] col;
        logic       hdr;
    } dir_row_t;

    localparam int N_DIR = 26;

    // pinned rows give exactly one word, typed in here
    dir_row_t dir_rows [N_DIR] = '{
        '{REQ_DATA, MARK_0,     1'b0, KIND_CONTENT,   8'h00, 5'd0, 1'b0},
        '{REQ_DATA, MARK_1,     1'b0, KIND_CONTENT,   8'h00, 5'd0, 1'b0},
        '{REQ_DATA, MARK_2,     1'b0, KIND_CONTENT,   8'h00, 5'd0, 1'b0},
        '{REQ_DATA, 8'h61,      1'b1, KIND_CONTENT,   8'h61, 5'd0, 1'b1},
        '{REQ_DATA, CHAR_COMMA, 1'b1, KIND_FIELD_END, 8'h00, 5'd0, 1'b1},
        '{REQ_DATA, CHAR_QUOTE, 1'b0, KIND_CONTENT,   8'h00, 5'd0, 1'b0},
        '{REQ_DATA, CHAR_QUOTE, 1'b0, KIND_CONTENT,   8'h00, 5'd0, 1'b0},
        '{REQ_DATA, CHAR_QUOTE, 1'b1, KIND_CONTENT,   CHAR_QUOTE, 5'd1, 1'b1},
        '{REQ_DATA, CHAR_COMMA, 1'b0, KIND_CONTENT,   8'h00, 5'd0, 1'b0},
        '{REQ_DATA, CHAR_QUOTE, 1'b0, KIND_CONTENT,   8'h00, 5'd0, 1'b0},
        '{REQ_DATA, CHAR_COMMA, 1'b1, KIND_FIELD_END, 8'h00, 5'd1, 1'b1},
        '{REQ_DATA, CHAR_NL,    1'b0, KIND_CONTENT,   8'h00, 5'd0, 1'b0},
        '{REQ_DATA, CHAR_NL,    1'b0, KIND_CONTENT,   8'h00, 5'd0, 1'b0},
        '{REQ_DATA, 8'h00,      1'b1, KIND_CONTENT,   8'h00, 5'd0, 1'b0},
        '{REQ_DATA, 8'hFF,      1'b1, KIND_CONTENT,   8'hFF, 5'd0, 1'b0},
        '{REQ_EOF,  8'h00,      1'b0, KIND_CONTENT,   8'h00, 5'd0, 1'b0},
        '{REQ_DATA, MARK_0,     1'b0, KIND_CONTENT,   8'h00, 5'd0, 1'b0},
        '{REQ_DATA, MARK_1,     1'b0, KIND_CONTENT,   8'h00, 5'd0, 1'b0},
        '{REQ_DATA, 8'h71,      1'b0, KIND_CONTENT,   8'h00, 5'd0, 1'b0},
        '{REQ_EOF,  8'hFF,      1'b0, KIND_CONTENT,   8'h00, 5'd0, 1'b0},
        '{REQ_EOF,  8'h00,      1'b0, KIND_CONTENT,   8'h00, 5'd0, 1'b0},
        '{REQ_DATA, MARK_0,     1'b0, KIND_CONTENT,   8'h00, 5'd0, 1'b0},
        '{REQ_EOF,  8'h00,      1'b0, KIND_CONTENT,   8'h00, 5'd0, 1'b0},
        '{REQ_DATA, CHAR_NL,    1'b0, KIND_CONTENT,   8'h00, 5'd0, 1'b0},
        '{REQ_DATA, CHAR_QUOTE, 1'b0, KIND_CONTENT,   8'h00, 5'd0, 1'b0},
        '{REQ_DATA, CHAR_QUOTE, 1'b0, KIND_CONTENT,   8'h00, 5'd0, 1'b0}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    // predictor state
    logic       in_quotes;
    logic       quote_held;
    logic       hdr_done;
    logic       line_dirty;
    logic       file_start;
    logic [5:0] fld_idx;
    logic [5:0] hdr_cols;
    logic [1:0] bom_cnt;

    token_t burst_q[$];
    token_t expected_tokens[$];
    int     err_count   = 0;
    int     burst_left  = 0;
    int     cycle_count = 0;
    int     rx_left     = 0;
    int     rx_mode     = 0;

    csv_record_tokenizer_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic flag_error(input string msg);
        err_count++;
        $display("ERROR %0t: %s", $time, msg);
    endtask

    function automatic void clear_tokenizer();
        in_quotes  = 1'b0;
        quote_held = 1'b0;
        hdr_done   = 1'b0;
        line_dirty = 1'b0;
        file_start = 1'b1;
        fld_idx    = '0;
        hdr_cols   = '0;
        bom_cnt    = '0;
    endfunction

    function automatic void add_token(input kind_t k, input logic [7:0] c, input int col);
        token_t t;
        t.kind = k;
        t.ch   = c;
        t.col  = col[4:0];
        t.hdr  = !hdr_done;
        t.last = 1'b0;
        burst_q = {burst_q, t};
    endfunction

    function automatic int col_cap();
        return hdr_done ? int'(hdr_cols) : MAX_COLUMNS;
    endfunction

    function automatic void close_line();
        int cap;
        cap = col_cap();
        // a data line with no bytes at all is skipped
        if (!(hdr_done && !line_dirty))
        begin
            if (fld_idx < cap)
                add_token(KIND_FIELD_END, 8'h00, int'(fld_idx));
            if (hdr_done)
                for (int c = int'(fld_idx) + 1; c < cap; c++)
                    add_token(KIND_FIELD_END, 8'h00, c);
            add_token(KIND_RECORD_END, 8'h00, 0);
            if (!hdr_done)
            begin
                hdr_cols = (int'(fld_idx) + 1 > MAX_COLUMNS) ? 6'(MAX_COLUMNS)
                                                             : 6'(int'(fld_idx) + 1);
                hdr_done = 1'b1;
            end
        end
        in_quotes  = 1'b0;
        quote_held = 1'b0;
        fld_idx    = '0;
        line_dirty = 1'b0;
    endfunction

    function automatic void feed_byte(input logic [7:0] b);
        int cap;
        if (b == CHAR_NL)
        begin
            close_line();
            return;
        end
        line_dirty = 1'b1;
        cap = col_cap();
        // quote after a quote inside quotes: the pair stands for one quote
        if (quote_held)
        begin
            quote_held = 1'b0;
            if (b == CHAR_QUOTE)
            begin
                if (fld_idx < cap)
                    add_token(KIND_CONTENT, b, int'(fld_idx));
                return;
            end
            in_quotes = 1'b0;
        end
        if (b == CHAR_QUOTE)
        begin
            if (in_quotes)
                quote_held = 1'b1;
            else
                in_quotes = 1'b1;
        end
        else if (b == CHAR_COMMA && !in_quotes)
        begin
            if (fld_idx < cap)
            begin
                add_token(KIND_FIELD_END, 8'h00, int'(fld_idx));
                fld_idx++;
            end
        end
        else if (fld_idx < cap)
            add_token(KIND_CONTENT, b, int'(fld_idx));
    endfunction

    // partial mark bytes go on as ordinary data
    function automatic void flush_bom();
        int n;
        n = bom_cnt;
        file_start = 1'b0;
        bom_cnt    = '0;
        for (int i = 0; i < n; i++)
            feed_byte(BOM_SEQ[8*i +: 8]);
    endfunction

    function automatic void predict_tokens(input logic req, input logic [7:0] b);
        int m;
        burst_q.delete();
        if (req == REQ_DATA)
        begin
            if (file_start)
            begin
                m = (bom_cnt < 3) ? int'(bom_cnt) : 0;
                if (b == BOM_SEQ[8*m +: 8])
                begin
                    line_dirty = 1'b1;
                    if (m + 1 >= 3)
                    begin
                        bom_cnt    = '0;
                        file_start = 1'b0;
                    end
                    else
                        bom_cnt = 2'(m + 1);
                end
                else
                begin
                    flush_bom();
                    feed_byte(b);
                end
            end
            else
                feed_byte(b);
        end
        else
        begin
            if (file_start)
                flush_bom();
            if (line_dirty)
                close_line();
            clear_tokenizer();
        end
        if (burst_q.size() > 0)
            burst_q[burst_q.size() - 1].last = 1'b1;
    endfunction

    // entered and left just after a falling edge
    task automatic send_word(input logic req, input logic [7:0] b, input logic pinned,
                             input token_t typed);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
            if (gap > 0)
            begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        s_tvalid = 1'b1;
        s_tuser  = req;
        s_tdata  = b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_tokens(req, b);
        if (pinned)
            expected_tokens = {expected_tokens, typed};
        else
            expected_tokens = {expected_tokens, burst_q};
        burst_left--;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid   = 1'b0;
        burst_left = 0;
        while (expected_tokens.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        c = 8'($urandom_range(8'h20, 8'h7e));
        if (c == CHAR_COMMA || c == CHAR_QUOTE)
            c = 8'h5f;
        return c;
    endfunction

    function automatic void add_word(ref logic [8:0] words[$], input logic req,
                                     input logic [7:0] b);
        logic [8:0] w;
        w = {req, b};
        words = {words, w};
    endfunction

    function automatic void add_field(ref logic [8:0] words[$], input bit narrow);
        int         style;
        int         n;
        logic [7:0] c;
        style = $urandom_range(0, 9);
        n = narrow ? $urandom_range(0, 1) : $urandom_range(0, 4);
        if (style < 5)
        begin
            repeat (n)
                add_word(words, REQ_DATA, plain_char());
        end
        else if (style < 8)
        begin
            add_word(words, REQ_DATA, CHAR_QUOTE);
            repeat (n)
            begin
                case ($urandom_range(0, 5))
                    0:
                    begin
                        add_word(words, REQ_DATA, CHAR_QUOTE);
                        add_word(words, REQ_DATA, CHAR_QUOTE);
                    end
                    1:       add_word(words, REQ_DATA, CHAR_COMMA);
                    default: add_word(words, REQ_DATA, plain_char());
                endcase
            end
            // now and then leave the quote open or put junk after it
            if ($urandom_range(0, 7) != 0)
                add_word(words, REQ_DATA, CHAR_QUOTE);
            if ($urandom_range(0, 5) == 0)
                add_word(words, REQ_DATA, plain_char());
        end
        else
        begin
            repeat (n + 1)
            begin
                c = 8'($urandom_range(0, 255));
                add_word(words, REQ_DATA, c);
            end
        end
    endfunction

    task automatic send_random_file(inout int sent);
        logic [8:0] words[$];
        logic [7:0] c;
        int         lines;
        int         cols;
        token_t     none;
        none = '0;
        case ($urandom_range(0, 7))
            0:
            begin
                add_word(words, REQ_DATA, MARK_0);
                add_word(words, REQ_DATA, MARK_1);
                add_word(words, REQ_DATA, MARK_2);
            end
            1: add_word(words, REQ_DATA, MARK_0);
            2:
            begin
                add_word(words, REQ_DATA, MARK_0);
                add_word(words, REQ_DATA, MARK_1);
            end
            default: ;
        endcase
        lines = $urandom_range(1, 6);
        for (int ln = 0; ln < lines; ln++)
        begin
            if (ln > 0 && $urandom_range(0, 5) == 0)
                cols = 0;
            else if ($urandom_range(0, (ln == 0) ? 3 : 7) == 0)
                cols = $urandom_range(30, 40);
            else
                cols = $urandom_range(1, 5);
            for (int f = 0; f < cols; f++)
            begin
                if (f > 0)
                    add_word(words, REQ_DATA, CHAR_COMMA);
                add_field(words, cols > 8);
            end
            if (ln < lines - 1 || $urandom_range(0, 1) == 0)
                add_word(words, REQ_DATA, CHAR_NL);
        end
        if ($urandom_range(0, 9) != 0)
        begin
            c = 8'($urandom_range(0, 255));
            add_word(words, REQ_EOF, c);
        end
        // the word budget may cut the last file short
        foreach (words[i])
        begin
            if (sent < RANDOM_WORDS)
            begin
                send_word(words[i][8], words[i][7:0], 1'b0, none);
                sent++;
            end
        end
    endtask

    // receiver: modes of free flow, coin-flip, light and heavy stalling
    initial
        m_tready = 1'b0;

    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(8, 48);
        end
        rx_left--;
        case (rx_mode)
            0:       m_tready = 1'b1;
            1:       m_tready = 1'($urandom_range(0, 1));
            2:       m_tready = ($urandom_range(0, 7) != 0);
            default: m_tready = ($urandom_range(0, 9) == 0);
        endcase
    end

    always @(posedge clk)
    begin : check_words
        token_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_tokens.size() == 0)
                flag_error($sformatf("word with none expected: kind %0d char %02h col %0d",
                                     m_tuser[1:0], m_tdata[7:0], m_tdata[12:8]));
            else
            begin
                want = expected_tokens.pop_front();
                if (m_tuser[1:0] != want.kind)
                    flag_error($sformatf("kind %0d, expected %0d", m_tuser[1:0], want.kind));
                if (m_tdata[7:0] != want.ch)
                    flag_error($sformatf("char %02h, expected %02h", m_tdata[7:0], want.ch));
                if (m_tdata[12:8] != want.col)
                    flag_error($sformatf("column %0d, expected %0d", m_tdata[12:8], want.col));
                if (m_tuser[2] != want.hdr)
                    flag_error($sformatf("header flag %0b, expected %0b", m_tuser[2], want.hdr));
                if (m_tlast != want.last)
                    flag_error($sformatf("tlast %0b, expected %0b", m_tlast, want.last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        token_t typed;
        int     sent;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tuser  = REQ_DATA;
        sent     = 0;
        clear_tokenizer();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
        begin
            typed = '{dir_rows[i].kind, dir_rows[i].ch, dir_rows[i].col, dir_rows[i].hdr, 1'b1};
            send_word(dir_rows[i].req, dir_rows[i].b, dir_rows[i].pinned, typed);
        end
        wait_drained();

        while (sent < RANDOM_WORDS)
        begin
            send_random_file(sent);
            if ($urandom_range(0, 3) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (20) @(negedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
